[hdl/fcbs_pkg.sv]
// shared constants, codes and control types for the bus cycle stretcher
`timescale 1ns / 1ps
`default_nettype none
package fcbs_pkg;

	// counter width default and fixed field widths
	localparam int COUNTER_BITS_DEF = 48;
	localparam int BUS_BITS         = 48;
	localparam int PHASE_BITS       = 27;
	localparam int ACC_BITS         = PHASE_BITS + 1;
	localparam int STEP_BITS        = 21;
	localparam int OP_BITS          = 3;
	localparam int AMT_BITS         = 4;
	localparam int HALF_BITS        = 6;
	localparam int CFG_IDX_BITS     = 1;
	localparam int CFG_DATA_BITS    = STEP_BITS;

	// register indexes
	localparam logic [CFG_IDX_BITS-1:0] REG_FAST_MODE     = 1'd0;
	localparam logic [CFG_IDX_BITS-1:0] REG_BUS_RATE_STEP = 1'd1;

	localparam logic                 FAST_MODE_RST = 1'b1;
	localparam logic [STEP_BITS-1:0] STEP_RST      = 21'd985248;

	// access kinds
	localparam logic [OP_BITS-1:0] OP_ADD     = 3'd0;
	localparam logic [OP_BITS-1:0] OP_EPROM   = 3'd1;
	localparam logic [OP_BITS-1:0] OP_READ    = 3'd2;
	localparam logic [OP_BITS-1:0] OP_IOW     = 3'd3;
	localparam logic [OP_BITS-1:0] OP_SLOWIOW = 3'd4;
	localparam logic [OP_BITS-1:0] OP_BUFW    = 3'd5;
	localparam logic [OP_BITS-1:0] OP_RESET   = 3'd6;

	// phase constants
	localparam logic [PHASE_BITS-1:0] WRAP_UNITS  = 27'd20000000;
	localparam logic [PHASE_BITS-1:0] READ_THRESH = 27'd31730000;
	localparam logic [PHASE_BITS-1:0] READ_TAKE   = 27'd20600000;
	localparam logic [PHASE_BITS-1:0] SLOW_THRESH = 27'd56550000;
	localparam logic [PHASE_BITS-1:0] SLOW_TAKE   = 27'd40600000;
	localparam logic [PHASE_BITS-1:0] BUF_PHASE   = 27'd13000000;
	localparam logic [1:0]            READ_SLOW   = 2'd1;
	localparam logic [1:0]            SLOW_SLOW   = 2'd2;
	localparam logic [2:0]            EPROM_CYC   = 3'd3;

	// remainder unit: deficit is below the largest threshold
	localparam int DEF_BITS     = 26;
	localparam int DIV_CNT_BITS = $clog2(DEF_BITS);
	localparam logic [DIV_CNT_BITS-1:0] DIV_LAST = DIV_CNT_BITS'(DEF_BITS - 1);

	// phase / 1000000 as multiply by rounded-up reciprocal of 2^47
	localparam int RECIP_BITS = 28;
	localparam int HALF_SHIFT = 47;
	localparam int PROD_BITS  = PHASE_BITS + RECIP_BITS;
	localparam logic [RECIP_BITS-1:0] HALF_RECIP = 28'd140737489;

	typedef struct packed {
		logic load;
		logic add_fast;
		logic add_slow;
		logic wrap_step;
		logic eprom;
		logic await_buf;
		logic fix_thresh;
		logic div_init;
		logic div_step;
		logic adjust;
		logic finish;
		logic buf_set;
		logic timing_rst;
		logic out_load;
	} cmd_t;

	typedef struct packed {
		logic [OP_BITS-1:0] op;
		logic               fast;
		logic               ph_over;
		logic               below;
		logic               step_zero;
		logic               out_free;
	} sts_t;

endpackage
`default_nettype wire

[hdl/fcbs_if.sv]
// access and result channel interfaces
`timescale 1ns / 1ps
`default_nettype none
interface fcbs_in_if;
	logic                            valid;
	logic                            ready;
	logic [fcbs_pkg::OP_BITS-1:0]   op;
	logic [fcbs_pkg::AMT_BITS-1:0]  cycle_count;

	modport source (output valid, output op, output cycle_count, input ready);
	modport sink (input valid, input op, input cycle_count, output ready);
endinterface

interface fcbs_out_if;
	logic                            valid;
	logic                            ready;
	logic [fcbs_pkg::BUS_BITS-1:0]  bus_clock;
	logic [fcbs_pkg::HALF_BITS-1:0] half_cycle;
	logic                            half_cycle_valid;

	modport source (output valid, output bus_clock, output half_cycle,
		output half_cycle_valid, input ready);
	modport sink (input valid, input bus_clock, input half_cycle,
		input half_cycle_valid, output ready);
endinterface
`default_nettype wire

[hdl/fast_cpu_bus_cycle_stretcher_top.sv]
// An access is accepted in idle, decoded in exec and loaded into the result register in out;
// in fast mode a buffered write also passes the buffer state, and a cycle add the wrap state per carry.
// A read or io stretch runs a remainder unit one bit per cycle over the 26-bit deficit, which it
// skips when the rate step is zero. A result held by a stalled sink holds off the next access.
// Throughput: one access at a time, next accepted the cycle after the result is loaded.
// Reset (arst_n, asynchronous): counter, phase, write buffer time zero, fast mode on, step 985248.
`timescale 1ns / 1ps
`default_nettype none
module fast_cpu_bus_cycle_stretcher_top #(
	parameter int COUNTER_BITS = fcbs_pkg::COUNTER_BITS_DEF
) (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	input  wire logic                               cfg_we,
	input  wire logic [fcbs_pkg::CFG_IDX_BITS-1:0]  cfg_index,
	input  wire logic [fcbs_pkg::CFG_DATA_BITS-1:0] cfg_wdata,
	fcbs_in_if.sink                                 req,
	fcbs_out_if.source                              rsp
);
	import fcbs_pkg::*;

	cmd_t ctl_cmd;
	sts_t ctl_sts;
	logic req_ready;

	assign req.ready = req_ready;

	fcbs_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_ready (req_ready),
		.sts       (ctl_sts),
		.cmd       (ctl_cmd)
	);

	fcbs_dp #(
		.COUNTER_BITS (COUNTER_BITS)
	) u_dp (
		.clk                  (clk),
		.arst_n               (arst_n),
		.cfg_we               (cfg_we),
		.cfg_index            (cfg_index),
		.cfg_wdata            (cfg_wdata),
		.req_op               (req.op),
		.req_cycle_count      (req.cycle_count),
		.rsp_ready            (rsp.ready),
		.rsp_valid            (rsp.valid),
		.rsp_bus_clock        (rsp.bus_clock),
		.rsp_half_cycle       (rsp.half_cycle),
		.rsp_half_cycle_valid (rsp.half_cycle_valid),
		.cmd                  (ctl_cmd),
		.sts                  (ctl_sts)
	);

endmodule
`default_nettype wire

[hdl/fcbs_ctrl.sv]
// sequencer for one access: decode, wrap loop, remainder steps, result load
`timescale 1ns / 1ps
`default_nettype none
module fcbs_ctrl (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire fcbs_pkg::sts_t sts,
	output fcbs_pkg::cmd_t      cmd
);
	import fcbs_pkg::*;

	localparam logic [3:0] S_IDLE = 4'd0;
	localparam logic [3:0] S_EXEC = 4'd1;
	localparam logic [3:0] S_WRAP = 4'd2;
	localparam logic [3:0] S_DEF  = 4'd3;
	localparam logic [3:0] S_DIV  = 4'd4;
	localparam logic [3:0] S_ADJ  = 4'd5;
	localparam logic [3:0] S_FIN  = 4'd6;
	localparam logic [3:0] S_BUF  = 4'd7;
	localparam logic [3:0] S_OUT  = 4'd8;

	logic [3:0]              state_q, state_d;
	logic [DIV_CNT_BITS-1:0] div_cnt_q;

	always_comb begin
		cmd       = '0;
		state_d   = state_q;
		req_ready = (state_q == S_IDLE);
		case (state_q)
			S_IDLE: begin
				if (req_valid) begin
					cmd.load = 1'b1;
					state_d  = S_EXEC;
				end
			end
			S_EXEC: begin
				state_d = S_OUT;
				case (sts.op)
					OP_RESET: cmd.timing_rst = 1'b1;
					OP_ADD: begin
						if (sts.fast) begin
							cmd.add_fast = 1'b1;
							state_d      = S_WRAP;
						end else begin
							cmd.add_slow = 1'b1;
						end
					end
					OP_EPROM: cmd.eprom = sts.fast;
					OP_READ, OP_IOW, OP_SLOWIOW: begin
						if (sts.fast) begin
							cmd.await_buf = 1'b1;
							state_d       = S_DEF;
						end
					end
					OP_BUFW: begin
						if (sts.fast) begin
							cmd.await_buf = 1'b1;
							state_d       = S_BUF;
						end
					end
					default: state_d = S_OUT;
				endcase
			end
			S_WRAP: begin
				if (sts.ph_over) begin
					cmd.wrap_step = 1'b1;
				end else begin
					state_d = S_OUT;
				end
			end
			S_DEF: begin
				state_d = S_FIN;
				if (sts.below) begin
					if (sts.step_zero) begin
						cmd.fix_thresh = 1'b1;
					end else begin
						cmd.div_init = 1'b1;
						state_d      = S_DIV;
					end
				end
			end
			S_DIV: begin
				cmd.div_step = 1'b1;
				if (div_cnt_q == DIV_LAST) begin
					state_d = S_ADJ;
				end
			end
			S_ADJ: begin
				cmd.adjust = 1'b1;
				state_d    = S_FIN;
			end
			S_FIN: begin
				cmd.finish = 1'b1;
				state_d    = S_OUT;
			end
			S_BUF: begin
				cmd.buf_set = 1'b1;
				state_d     = S_OUT;
			end
			S_OUT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= S_IDLE;
			div_cnt_q <= '0;
		end else begin
			state_q <= state_d;
			if (cmd.div_init) begin
				div_cnt_q <= '0;
			end else if (cmd.div_step) begin
				div_cnt_q <= div_cnt_q + DIV_CNT_BITS'(1);
			end
		end
	end

endmodule
`default_nettype wire

[hdl/fcbs_dp.sv]
// counter, phase, write buffer time, remainder unit and result register
`timescale 1ns / 1ps
`default_nettype none
module fcbs_dp #(
	parameter int COUNTER_BITS = fcbs_pkg::COUNTER_BITS_DEF
) (
	input  wire logic                                clk,
	input  wire logic                                arst_n,
	input  wire logic                                cfg_we,
	input  wire logic [fcbs_pkg::CFG_IDX_BITS-1:0]   cfg_index,
	input  wire logic [fcbs_pkg::CFG_DATA_BITS-1:0]  cfg_wdata,
	input  wire logic [fcbs_pkg::OP_BITS-1:0]        req_op,
	input  wire logic [fcbs_pkg::AMT_BITS-1:0]       req_cycle_count,
	input  wire logic                                rsp_ready,
	output logic                                     rsp_valid,
	output logic [fcbs_pkg::BUS_BITS-1:0]            rsp_bus_clock,
	output logic [fcbs_pkg::HALF_BITS-1:0]           rsp_half_cycle,
	output logic                                     rsp_half_cycle_valid,
	input  wire fcbs_pkg::cmd_t                      cmd,
	output fcbs_pkg::sts_t                           sts
);
	import fcbs_pkg::*;

	logic                    fast_q;
	logic [STEP_BITS-1:0]    step_q;
	logic [COUNTER_BITS-1:0] cnt_q;
	logic [ACC_BITS-1:0]     ph_q;
	logic [COUNTER_BITS-1:0] bdc_q;
	logic                    bdp_set_q;
	logic [OP_BITS-1:0]      op_q;
	logic [AMT_BITS-1:0]     amt_q;
	logic [STEP_BITS-1:0]    rem_q;
	logic [DEF_BITS-1:0]     def_q;
	logic                    out_vld_q;
	logic [BUS_BITS-1:0]     bus_clock_q;
	logic [HALF_BITS-1:0]    half_q;
	logic                    half_vld_q;

	logic [PHASE_BITS-1:0]   bdp;
	logic [PHASE_BITS-1:0]   thresh;
	logic [PHASE_BITS-1:0]   take;
	logic [1:0]              slow;
	logic                    buf_later;
	logic [ACC_BITS-1:0]     add_sum;
	logic [ACC_BITS-1:0]     eprom_sum;
	logic [ACC_BITS-1:0]     eprom_wrapped;
	logic [ACC_BITS-1:0]     fin_ph;
	logic [STEP_BITS:0]      trial;
	logic [STEP_BITS:0]      trial_sub;
	logic [PROD_BITS-1:0]    half_prod;

	assign bdp = bdp_set_q ? BUF_PHASE : '0;

	// long slow io write has its own threshold
	assign thresh = (op_q == OP_SLOWIOW) ? SLOW_THRESH : READ_THRESH;
	assign take   = (op_q == OP_SLOWIOW) ? SLOW_TAKE : READ_TAKE;
	assign slow   = (op_q == OP_SLOWIOW) ? SLOW_SLOW : READ_SLOW;

	assign buf_later = {bdc_q, bdp} > {cnt_q, ph_q[PHASE_BITS-1:0]};

	assign add_sum       = ph_q + ACC_BITS'(step_q) * ACC_BITS'(amt_q);
	assign eprom_sum     = ph_q + ACC_BITS'(step_q) * ACC_BITS'(EPROM_CYC);
	assign eprom_wrapped = eprom_sum - ACC_BITS'(WRAP_UNITS);
	assign fin_ph        = ph_q - ACC_BITS'(take);

	// one restoring remainder step per cycle
	assign trial     = {rem_q, def_q[DEF_BITS-1]};
	assign trial_sub = trial - (STEP_BITS+1)'(step_q);

	assign half_prod = ph_q[PHASE_BITS-1:0] * HALF_RECIP;

	assign sts.op        = op_q;
	assign sts.fast      = fast_q;
	assign sts.ph_over   = ph_q > ACC_BITS'(WRAP_UNITS);
	assign sts.below     = ph_q < ACC_BITS'(thresh);
	assign sts.step_zero = (step_q == '0);
	assign sts.out_free  = !out_vld_q || rsp_ready;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			fast_q    <= FAST_MODE_RST;
			step_q    <= STEP_RST;
			cnt_q     <= '0;
			ph_q      <= '0;
			bdc_q     <= '0;
			bdp_set_q <= 1'b0;
			out_vld_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_FAST_MODE:     fast_q <= cfg_wdata[0];
					REG_BUS_RATE_STEP: step_q <= cfg_wdata[STEP_BITS-1:0];
					default:           fast_q <= fast_q;
				endcase
			end

			if (cmd.add_fast) begin
				ph_q <= add_sum;
			end else if (cmd.add_slow) begin
				cnt_q <= cnt_q + COUNTER_BITS'(amt_q);
			end else if (cmd.wrap_step) begin
				ph_q  <= ph_q - ACC_BITS'(WRAP_UNITS);
				cnt_q <= cnt_q + COUNTER_BITS'(1);
			end else if (cmd.eprom) begin
				if (eprom_sum > ACC_BITS'(WRAP_UNITS)) begin
					ph_q  <= {1'b0, eprom_wrapped[PHASE_BITS-1:0]};
					cnt_q <= cnt_q + COUNTER_BITS'(1);
				end else begin
					ph_q <= {1'b0, eprom_sum[PHASE_BITS-1:0]};
				end
			end else if (cmd.await_buf) begin
				if (buf_later) begin
					cnt_q <= bdc_q;
					ph_q  <= ACC_BITS'(bdp);
				end
			end else if (cmd.fix_thresh) begin
				ph_q <= ACC_BITS'(thresh);
			end else if (cmd.adjust) begin
				// land on the first multiple of the step at or past the threshold
				if (rem_q == '0) begin
					ph_q <= ACC_BITS'(thresh);
				end else begin
					ph_q <= ACC_BITS'(thresh) + ACC_BITS'(step_q - rem_q);
				end
			end else if (cmd.finish) begin
				ph_q  <= {1'b0, fin_ph[PHASE_BITS-1:0]};
				cnt_q <= cnt_q + COUNTER_BITS'(slow);
			end else if (cmd.buf_set) begin
				bdc_q     <= cnt_q + COUNTER_BITS'(1);
				bdp_set_q <= 1'b1;
			end else if (cmd.timing_rst) begin
				bdc_q     <= cnt_q;
				bdp_set_q <= 1'b0;
				ph_q      <= '0;
			end

			if (cmd.out_load) begin
				out_vld_q <= 1'b1;
			end else if (rsp_ready) begin
				out_vld_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			op_q  <= req_op;
			amt_q <= req_cycle_count;
		end
		if (cmd.div_init) begin
			rem_q <= '0;
			def_q <= DEF_BITS'(thresh - ph_q[PHASE_BITS-1:0]);
		end else if (cmd.div_step) begin
			rem_q <= trial_sub[STEP_BITS] ? trial[STEP_BITS-1:0] : trial_sub[STEP_BITS-1:0];
			def_q <= {def_q[DEF_BITS-2:0], 1'b0};
		end
		if (cmd.out_load) begin
			bus_clock_q <= BUS_BITS'(cnt_q);
			half_q      <= fast_q ? half_prod[HALF_SHIFT +: HALF_BITS] : '0;
			half_vld_q  <= fast_q;
		end
	end

	assign rsp_valid            = out_vld_q;
	assign rsp_bus_clock        = bus_clock_q;
	assign rsp_half_cycle       = half_q;
	assign rsp_half_cycle_valid = half_vld_q;

endmodule
`default_nettype wire
